/* sv/tspn_pkg.sv */
// shared constants, tables and types for the toy spn cipher
package tspn_pkg;

	localparam int unsigned BLK_W = 8;
	localparam int unsigned NIB_W = 4;
	localparam int unsigned NUM_RK = 4;
	localparam int unsigned CFG_IDX_W = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RK0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RK1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RK2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RK3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FINAL = 3'd4;

	// key reset values
	localparam logic [BLK_W-1:0] RK0_RST = 8'hE3;
	localparam logic [BLK_W-1:0] RK1_RST = 8'h2B;
	localparam logic [BLK_W-1:0] RK2_RST = 8'hF5;
	localparam logic [BLK_W-1:0] RK3_RST = 8'h9A;
	localparam logic [BLK_W-1:0] FINAL_RST = 8'h75;

	localparam logic [NIB_W-1:0] SBOX_FWD [16] = '{
		4'hE, 4'h4, 4'hD, 4'h1, 4'h2, 4'hF, 4'hB, 4'h8,
		4'h3, 4'hA, 4'h6, 4'hC, 4'h5, 4'h9, 4'h0, 4'h7
	};

	localparam logic [NIB_W-1:0] SBOX_REV [16] = '{
		4'hE, 4'h3, 4'h4, 4'h8, 4'h1, 4'hC, 4'hA, 4'hF,
		4'h7, 4'hD, 4'h9, 4'h6, 4'hB, 4'h2, 4'h0, 4'h5
	};

	// destination of each source bit
	localparam logic [2:0] BIT_DEST [8] = '{
		3'd0, 3'd4, 3'd6, 3'd5, 3'd1, 3'd3, 3'd2, 3'd7
	};

	// per-round control from the top level to a round unit
	typedef struct packed {
		logic decrypt;
		logic perm_en;
	} rnd_ctl_t;

	// bit permutation, its own inverse
	function automatic logic [BLK_W-1:0] perm(input logic [BLK_W-1:0] v);
		logic [BLK_W-1:0] r;
		r = '0;
		for (int i = 0; i < BLK_W; i++) begin
			r[BIT_DEST[i]] = v[i];
		end
		return r;
	endfunction

	function automatic logic [BLK_W-1:0] sub_fwd(input logic [BLK_W-1:0] v);
		return {SBOX_FWD[v[7:4]], SBOX_FWD[v[3:0]]};
	endfunction

	function automatic logic [BLK_W-1:0] sub_rev(input logic [BLK_W-1:0] v);
		return {SBOX_REV[v[7:4]], SBOX_REV[v[3:0]]};
	endfunction

endpackage

/* sv/tspn_round.sv */
// one cipher round, encrypt or decrypt, as combinational logic
module tspn_round (
	input  tspn_pkg::rnd_ctl_t           ctl,
	input  logic [tspn_pkg::BLK_W-1:0]   din,
	input  logic [tspn_pkg::BLK_W-1:0]   key_a,
	input  logic [tspn_pkg::BLK_W-1:0]   key_b,
	output logic [tspn_pkg::BLK_W-1:0]   dout
);

	logic [tspn_pkg::BLK_W-1:0] pre;
	logic [tspn_pkg::BLK_W-1:0] sub;

	// encrypt: key, s-box, then permute or whiten
	// decrypt: permute or un-whiten, inverse s-box, then key
	always_comb begin
		if (ctl.decrypt) begin
			pre  = ctl.perm_en ? tspn_pkg::perm(din) : (din ^ key_b);
			sub  = tspn_pkg::sub_rev(pre);
			dout = sub ^ key_a;
		end else begin
			pre  = din ^ key_a;
			sub  = tspn_pkg::sub_fwd(pre);
			dout = ctl.perm_en ? tspn_pkg::perm(sub) : (sub ^ key_b);
		end
	end

endmodule

/* sv/toy_spn_cipher_8bit.sv */
// top level: key registers and four-stage round pipeline with stall handling
//
// Encrypts (mode 0) or decrypts (mode 1) one 8-bit block per item. Each of the
// four rounds has its own pipeline stage, so an item passes data_s1, data_s2, data_s3
// and data_s4 before data_out, and a new item is taken every cycle while out_stall
// is low. When the output is stalled the stages fill up and in_stall rises only once
// all four hold an item. Keys are written through cfg_we/cfg_index/cfg_data and
// must only change while no item is in flight; indexes beyond final_key are ignored.
module toy_spn_cipher_8bit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tspn_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tspn_pkg::BLK_W-1:0]       cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             mode,
	input  logic [tspn_pkg::BLK_W-1:0]       data_in,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [tspn_pkg::BLK_W-1:0]       data_out
);

	logic [tspn_pkg::BLK_W-1:0] rk_q [tspn_pkg::NUM_RK];
	logic [tspn_pkg::BLK_W-1:0] final_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic mode_s1, mode_s2, mode_s3;
	logic [tspn_pkg::BLK_W-1:0] data_s1, data_s2, data_s3, data_s4;
	logic adv0, adv1, adv2, adv3;

	logic [tspn_pkg::BLK_W-1:0] rnd0, rnd1, rnd2, rnd3;
	logic [tspn_pkg::BLK_W-1:0] ka0, ka1, ka2, ka3;
	tspn_pkg::rnd_ctl_t ctl0, ctl1, ctl2, ctl3;

	// key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rk_q[0] <= tspn_pkg::RK0_RST;
			rk_q[1] <= tspn_pkg::RK1_RST;
			rk_q[2] <= tspn_pkg::RK2_RST;
			rk_q[3] <= tspn_pkg::RK3_RST;
			final_q <= tspn_pkg::FINAL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tspn_pkg::REG_RK0: rk_q[0] <= cfg_data;
				tspn_pkg::REG_RK1: rk_q[1] <= cfg_data;
				tspn_pkg::REG_RK2: rk_q[2] <= cfg_data;
				tspn_pkg::REG_RK3: rk_q[3] <= cfg_data;
				tspn_pkg::REG_FINAL: final_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage advance chain: a stage loads when it is empty or its own item moves on
	assign adv3     = !valid_s4 || !out_stall;
	assign adv2     = !valid_s3 || adv3;
	assign adv1     = !valid_s2 || adv2;
	assign adv0     = !valid_s1 || adv1;
	assign in_stall = !adv0;

	// round keys and control per stage; decryption walks the keys backwards
	assign ka0  = mode    ? rk_q[3] : rk_q[0];
	assign ka1  = mode_s1 ? rk_q[2] : rk_q[1];
	assign ka2  = mode_s2 ? rk_q[1] : rk_q[2];
	assign ka3  = mode_s3 ? rk_q[0] : rk_q[3];
	assign ctl0 = '{decrypt: mode,    perm_en: !mode};
	assign ctl1 = '{decrypt: mode_s1, perm_en: 1'b1};
	assign ctl2 = '{decrypt: mode_s2, perm_en: 1'b1};
	assign ctl3 = '{decrypt: mode_s3, perm_en: mode_s3};

	tspn_round u_rnd0 (.ctl(ctl0), .din(data_in), .key_a(ka0), .key_b(final_q), .dout(rnd0));
	tspn_round u_rnd1 (.ctl(ctl1), .din(data_s1), .key_a(ka1), .key_b(final_q), .dout(rnd1));
	tspn_round u_rnd2 (.ctl(ctl2), .din(data_s2), .key_a(ka2), .key_b(final_q), .dout(rnd2));
	tspn_round u_rnd3 (.ctl(ctl3), .din(data_s3), .key_a(ka3), .key_b(final_q), .dout(rnd3));

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (adv0) valid_s1 <= in_valid;
			if (adv1) valid_s2 <= valid_s1;
			if (adv2) valid_s3 <= valid_s2;
			if (adv3) valid_s4 <= valid_s3;
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (adv0) begin
			data_s1 <= rnd0;
			mode_s1 <= mode;
		end
		if (adv1) begin
			data_s2 <= rnd1;
			mode_s2 <= mode_s1;
		end
		if (adv2) begin
			data_s3 <= rnd2;
			mode_s3 <= mode_s2;
		end
		if (adv3) begin
			data_s4 <= rnd3;
		end
	end

	assign out_valid = valid_s4;
	assign data_out  = data_s4;

	// input is held off only when every stage is occupied and the output stalls
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && out_stall))
		else $error("in_stall with a free stage");

	// an accepted item always lands in the first stage
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("accepted item lost at stage one");

	// a blocked stage three keeps its item
	a_hold_s3: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && valid_s4 && out_stall) |=> (valid_s3 && $stable(data_s3)))
		else $error("stage three changed under stall");

	// stage three moves into a free or draining output stage
	a_move_s4: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !(valid_s4 && out_stall)) |=> (valid_s4 && data_s4 == $past(rnd3)))
		else $error("stage three item not forwarded");

endmodule
